### src/isitf_pkg.sv
package isitf_pkg;

  localparam int unsigned MaxChannelsDef  = 1024;
  localparam int unsigned MaxTimeStepsDef = 16777216;

  localparam int unsigned SampleW = 32;
  localparam int unsigned FloatW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDE_SAMPLES = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_POL_COUNT    = 3'd2,
    REG_DIM_COUNT    = 3'd3,
    REG_TIME_STEPS   = 3'd4
  } reg_idx_e;

  // Result of one conversion step.
  typedef struct packed {
    logic [9:0]  channel_index;
    logic        polarization_index;
    logic [24:0] array_offset;
    logic [31:0] float_bits;
    logic        block_end;
  } result_t;

  // Unsigned 32-bit integer to IEEE single, round to nearest even.
  function automatic logic [31:0] to_single(input logic [31:0] v);
    logic [4:0]  p;
    logic [7:0]  expo;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    logic [24:0] rnd;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    norm = v << (5'd31 - p);
    mant = norm[31:8];
    guard = norm[7];
    sticky = |norm[6:0];
    rnd = {1'b0, mant} + 25'(guard & (sticky | mant[0]));
    expo = 8'd127 + {3'd0, p};
    if (v == 32'd0) begin
      to_single = 32'd0;
    end else if (rnd[24]) begin
      to_single = {1'b0, expo + 8'd1, 23'd0};
    end else begin
      to_single = {1'b0, expo, rnd[22:0]};
    end
  endfunction

endpackage

### src/isitf_if.sv
interface isitf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/isitf_cfg_if.sv
interface isitf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [isitf_pkg::CfgIdxW-1:0] index;
  logic [isitf_pkg::CfgDatW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

### src/isitf_counters.sv
module isitf_counters #(
  parameter int unsigned MaxChannels  = isitf_pkg::MaxChannelsDef,
  parameter int unsigned MaxTimeSteps = isitf_pkg::MaxTimeStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [10:0] channel_count_i,
  input  logic [1:0]  pol_count_i,
  input  logic [1:0]  dim_count_i,
  input  logic [24:0] time_steps_i,
  output logic [9:0]  channel_index_o,
  output logic        polarization_index_o,
  output logic [24:0] array_offset_o,
  output logic        block_end_o
);
  import isitf_pkg::*;

  logic        dim_q, dim_d, pol_q, pol_d;
  logic [9:0]  chan_q, chan_d;
  logic [23:0] time_q, time_d;
  logic [25:0] nchan, ntime;
  logic        ndim2, npol2;
  logic        last_dim, last_pol, last_chan, last_time;

  // Effective counts: zero acts as one, large values saturate.
  always_comb begin
    nchan = (channel_count_i == 11'd0) ? 26'd1 :
            ({15'd0, channel_count_i} > 26'(MaxChannels)) ? 26'(MaxChannels) :
            {15'd0, channel_count_i};
    ntime = (time_steps_i == 25'd0) ? 26'd1 :
            ({1'b0, time_steps_i} > 26'(MaxTimeSteps)) ? 26'(MaxTimeSteps) :
            {1'b0, time_steps_i};
    ndim2 = dim_count_i[1];
    npol2 = pol_count_i[1];
  end

  assign last_dim  = !ndim2 || dim_q;
  assign last_pol  = !npol2 || pol_q;
  assign last_chan = {16'd0, chan_q} >= nchan - 26'd1;
  assign last_time = {2'd0, time_q} >= ntime - 26'd1;

  assign channel_index_o      = chan_q;
  assign polarization_index_o = pol_q;
  assign array_offset_o       = ndim2 ? {time_q, dim_q} : {1'b0, time_q} + {24'd0, dim_q};
  assign block_end_o          = last_dim && last_pol && last_chan && last_time;

  // Nested wrap of the sample position counters.
  always_comb begin
    dim_d  = dim_q;
    pol_d  = pol_q;
    chan_d = chan_q;
    time_d = time_q;
    if (!last_dim) begin
      dim_d = 1'b1;
    end else begin
      dim_d = 1'b0;
      if (!last_pol) begin
        pol_d = 1'b1;
      end else begin
        pol_d = 1'b0;
        if (!last_chan) begin
          chan_d = chan_q + 10'd1;
        end else begin
          chan_d = 10'd0;
          time_d = last_time ? 24'd0 : time_q + 24'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= 1'b0;
      pol_q  <= 1'b0;
      chan_q <= 10'd0;
      time_q <= 24'd0;
    end else if (step_i) begin
      dim_q  <= dim_d;
      pol_q  <= pol_d;
      chan_q <= chan_d;
      time_q <= time_d;
    end
  end

`ifndef SYNTHESIS
  a_dim_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !ndim2 |=> !dim_q) else $error("dimension counter left zero");
  a_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && block_end_o |=> chan_q == 10'd0 && time_q == 24'd0)
    else $error("counters did not restart after block end");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(time_q) && $stable(chan_q))
    else $error("counters moved without an item");
`endif
endmodule

### src/interleaved_sample_int_to_float.sv
// Interleaved unsigned sample to IEEE single-precision converter.
// Input channel in_if carries one raw sample_word per item; output channel
// out_if carries one result item per input item: channel, polarization,
// array offset, float encoding and the block end flag.
// Configuration is written over cfg_if (index 0..4), by the user only while
// the block is idle (not enforced by the block); cfg_if is always ready.
// The result becomes valid in the cycle after input acceptance.
// One item per cycle while out_if is ready. The conversion and counter
// logic sits between the input handshake and a single result register.
// The input is ready whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result stable
// and stops further input until it takes the item.
// Reset clears the result valid flag, all position counters, and the
// configuration to 16-bit samples with every count at one.
module interleaved_sample_int_to_float #(
  parameter int unsigned MaxChannels  = isitf_pkg::MaxChannelsDef,
  parameter int unsigned MaxTimeSteps = isitf_pkg::MaxTimeStepsDef
) (
  input logic clk_i,
  input logic rst_ni,
  isitf_stream_if.sink   in_if,
  isitf_stream_if.source out_if,
  isitf_cfg_if.sink      cfg_if
);
  import isitf_pkg::*;

  logic        wide_q;
  logic [10:0] chan_cnt_q;
  logic [1:0]  pol_cnt_q, dim_cnt_q;
  logic [24:0] time_cnt_q;
  logic        accept;
  logic        out_valid_q;
  result_t     res_q, res_d;
  logic [31:0] raw;

  assign cfg_if.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q     <= 1'b0;
      chan_cnt_q <= 11'd1;
      pol_cnt_q  <= 2'd1;
      dim_cnt_q  <= 2'd1;
      time_cnt_q <= 25'd1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_WIDE_SAMPLES:  wide_q     <= cfg_if.wdata[0];
        REG_CHANNEL_COUNT: chan_cnt_q <= cfg_if.wdata[10:0];
        REG_POL_COUNT:     pol_cnt_q  <= cfg_if.wdata[1:0];
        REG_DIM_COUNT:     dim_cnt_q  <= cfg_if.wdata[1:0];
        REG_TIME_STEPS:    time_cnt_q <= cfg_if.wdata[24:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  isitf_counters #(
    .MaxChannels (MaxChannels),
    .MaxTimeSteps(MaxTimeSteps)
  ) u_counters (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_i              (accept),
    .channel_count_i     (chan_cnt_q),
    .pol_count_i         (pol_cnt_q),
    .dim_count_i         (dim_cnt_q),
    .time_steps_i        (time_cnt_q),
    .channel_index_o     (res_d.channel_index),
    .polarization_index_o(res_d.polarization_index),
    .array_offset_o      (res_d.array_offset),
    .block_end_o         (res_d.block_end)
  );

  // Sample width selection and conversion.
  assign raw              = wide_q ? in_if.data : {16'd0, in_if.data[15:0]};
  assign res_d.float_bits = to_single(raw);

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |-> !in_if.ready) else $error("input taken over stalled result");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted item produced no result");
  a_narrow_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !wide_q |=> res_q.float_bits[6:0] == 7'd0) else $error("16-bit conversion inexact");
`endif
endmodule
